>>> rtl/fcml_pkg.sv
// Shared constants, codes, word types and log-add helpers for the frame CRF
// marginal loss unit. No dependencies.
package fcml_pkg;

	localparam int MAX_REFS    = 4;
	localparam int LABEL_WIDTH = 8;
	localparam int MAX_FRAMES  = 512;
	localparam int MAX_VALUES  = 1024;
	localparam int SCORE_BITS  = 24;
	localparam int LA_LEN      = 37;

	localparam int REF_W   = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
	localparam int NREF_W  = $clog2(MAX_REFS + 1);
	localparam int WORD_W  = $clog2(LABEL_WIDTH);
	localparam int FC_W    = $clog2(MAX_FRAMES + 1);
	localparam int VC_W    = $clog2(MAX_VALUES + 1);
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] FUNC_LABEL = 2'd0;
	localparam logic [1:0] FUNC_FRAME = 2'd1;
	localparam logic [1:0] FUNC_VALUE = 2'd2;
	localparam logic [1:0] FUNC_END   = 2'd3;

	localparam logic [1:0] KIND_ARG  = 2'd0;
	localparam logic [1:0] KIND_MARG = 2'd1;
	localparam logic [1:0] KIND_LOSS = 2'd2;

	localparam logic [1:0] CFG_LAMBDA = 2'd0;
	localparam logic [1:0] CFG_REFS   = 2'd1;

	typedef struct packed {
		logic [1:0]                   func;
		logic [4:0]                   label_slot;
		logic [9:0]                   label_value;
		logic signed [SCORE_BITS-1:0] score;
		logic                         last_value;
	} item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [8:0]         frame_num;
		logic [2:0]         arg_pos;
		logic [9:0]         best_index;
		logic signed [31:0] amount;
		logic               last;
	} res_t;

	typedef struct packed {
		logic room1;
		logic room2;
	} fifo_stat_t;

	function automatic logic [11:0] la_corr(input logic [5:0] i);
		logic [11:0] c;
		case (i)
			6'd0: c = 12'd2839;  6'd1: c = 12'd2359;  6'd2: c = 12'd1942;
			6'd3: c = 12'd1585;  6'd4: c = 12'd1283;  6'd5: c = 12'd1032;
			6'd6: c = 12'd825;   6'd7: c = 12'd656;   6'd8: c = 12'd520;
			6'd9: c = 12'd410;   6'd10: c = 12'd323;  6'd11: c = 12'd254;
			6'd12: c = 12'd199;  6'd13: c = 12'd156;  6'd14: c = 12'd122;
			6'd15: c = 12'd95;   6'd16: c = 12'd74;   6'd17: c = 12'd58;
			6'd18: c = 12'd45;   6'd19: c = 12'd35;   6'd20: c = 12'd28;
			6'd21: c = 12'd21;   6'd22: c = 12'd17;   6'd23: c = 12'd13;
			6'd24: c = 12'd10;   6'd25: c = 12'd8;    6'd26: c = 12'd6;
			6'd27: c = 12'd5;    6'd28: c = 12'd4;    6'd29: c = 12'd3;
			6'd30: c = 12'd2;    6'd31: c = 12'd2;    6'd32: c = 12'd1;
			6'd33: c = 12'd1;    6'd34: c = 12'd1;    6'd35: c = 12'd1;
			6'd36: c = 12'd1;
			default: c = 12'd0;
		endcase
		return c;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
		logic signed [31:0] r;
		if (v > 52'sd2147483647) r = 32'sh7FFFFFFF;
		else if (v < -52'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

	// hi + correction looked up by the gap, in units of 1/4 nat.
	function automatic logic signed [31:0] log_add(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [51:0] hi;
		logic signed [51:0] lo;
		logic [51:0]        d;
		logic signed [51:0] s;
		hi = (a > b) ? 52'(a) : 52'(b);
		lo = (a > b) ? 52'(b) : 52'(a);
		d  = hi - lo;
		if (d[51:10] < 42'd37) s = hi + 52'(la_corr(d[15:10]));
		else s = hi;
		return sat32(s);
	endfunction

endpackage

>>> rtl/fcml_out_fifo.sv
// Result queue of the frame CRF marginal loss unit: takes up to two words a
// cycle, delivers one while the receiver does not stall. Depends on fcml_pkg.
module fcml_out_fifo import fcml_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push0,
	input  res_t       res0,
	input  logic       push1,
	input  res_t       res1,
	output fifo_stat_t stat,
	output logic       out_valid,
	input  logic       out_stall,
	output res_t       out_res
);

	res_t               mem_q [FIFO_DEPTH];
	logic [FIFO_PW-1:0] rd_q;
	logic [FIFO_PW-1:0] wr_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic               pop;
	logic [FIFO_CW-1:0] npush;

	assign out_valid  = (cnt_q != '0);
	assign out_res    = mem_q[rd_q];
	assign pop        = out_valid && !out_stall;
	assign stat.room1 = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 1));
	assign stat.room2 = (cnt_q <= FIFO_CW'(FIFO_DEPTH - 2));
	assign npush      = FIFO_CW'(push0) + FIFO_CW'(push1);

	always_ff @(posedge clk) begin
		if (push0) mem_q[wr_q] <= res0;
		if (push1) mem_q[push0 ? wr_q + FIFO_PW'(1) : wr_q] <= res1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q  <= '0;
			wr_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (pop) rd_q <= rd_q + FIFO_PW'(1);
			wr_q  <= wr_q + FIFO_PW'(npush);
			cnt_q <= cnt_q + npush - FIFO_CW'(pop);
		end
	end

endmodule

>>> rtl/fcml_core.sv
// Example state of the frame CRF marginal loss unit: labels, running argmax
// and log-sum-exps, and the loss sequencer. Depends on fcml_pkg.
module fcml_core import fcml_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  item_t      item,
	output logic       take,
	input  fifo_stat_t stat,
	output logic       push0,
	output res_t       res0,
	output logic       push1,
	output res_t       res1,
	input  logic       cfg_valid,
	input  logic [1:0] cfg_index,
	input  logic [15:0] cfg_data
);

	localparam logic [1:0] SEQ_IDLE = 2'd0;
	localparam logic [1:0] SEQ_POS  = 2'd1;
	localparam logic [1:0] SEQ_MUL  = 2'd2;
	localparam logic [1:0] SEQ_OUT  = 2'd3;

	logic [9:0]         lbl_q [MAX_REFS][LABEL_WIDTH];
	logic [15:0]        lambda_q;
	logic [2:0]         refs_q;
	logic signed [31:0] ref_sums_q [MAX_REFS];
	logic [FC_W-1:0]    fc_q;
	logic [2:0]         ac_q;
	logic [VC_W-1:0]    vc_q;
	logic signed [SCORE_BITS-1:0] best_q;
	logic [9:0]         best_idx_q;
	logic signed [31:0] arg_lse_q, frame_sum_q, norm_q, gt_q;
	logic               open_q, has_norm_q, full_q;
	logic [1:0]         seq_q;
	logic [NREF_W-1:0]  ridx_q;
	logic signed [31:0] pos_q;
	logic signed [49:0] prod_q;

	logic signed [31:0] n_ref_sums [MAX_REFS];
	logic [FC_W-1:0]    n_fc;
	logic [2:0]         n_ac;
	logic [VC_W-1:0]    n_vc;
	logic signed [SCORE_BITS-1:0] n_best;
	logic [9:0]         n_best_idx;
	logic signed [31:0] n_arg_lse, n_frame_sum, n_norm, n_gt;
	logic               n_open, n_has_norm, n_full;
	logic [1:0]         n_seq;
	logic [NREF_W-1:0]  n_ridx;
	logic signed [31:0] n_pos;
	logic [NREF_W-1:0]  nref;
	logic signed [31:0] sc;
	logic               arg_ok, counted;
	logic [WORD_W-1:0]  arg_word;
	logic signed [51:0] loss;

	assign sc       = 32'(item.score);
	assign arg_ok   = (32'(ac_q) + 1 < LABEL_WIDTH);
	assign arg_word = WORD_W'(ac_q + 3'd1);
	assign take     = item_valid && (seq_q == SEQ_IDLE) && stat.room2;
	assign loss     = 52'(pos_q) - 52'(norm_q) + ((52'(prod_q) + 52'sd2048) >>> 12);

	always_comb begin
		if (refs_q == '0) nref = NREF_W'(1);
		else if (32'(refs_q) > MAX_REFS) nref = NREF_W'(MAX_REFS);
		else nref = NREF_W'(refs_q);
	end

	always_comb begin
		n_ref_sums = ref_sums_q;
		n_fc = fc_q; n_ac = ac_q; n_vc = vc_q;
		n_best = best_q; n_best_idx = best_idx_q;
		n_arg_lse = arg_lse_q; n_frame_sum = frame_sum_q;
		n_norm = norm_q; n_gt = gt_q;
		n_open = open_q; n_has_norm = has_norm_q; n_full = full_q;
		n_seq = seq_q; n_ridx = ridx_q; n_pos = pos_q;
		push0 = 1'b0; push1 = 1'b0;
		res0 = '0; res1 = '0;
		counted = 1'b0;
		if (take) begin
			// A frame start or end of example closes an open frame first.
			if ((item.func == FUNC_FRAME || item.func == FUNC_END) && open_q) begin
				push0           = 1'b1;
				res0.kind       = KIND_MARG;
				res0.frame_num  = fc_q[8:0];
				res0.amount     = frame_sum_q;
				res0.last       = (item.func == FUNC_FRAME);
				if (32'(fc_q) == 32'(lbl_q[0][0])) n_gt = frame_sum_q;
				n_norm     = has_norm_q ? log_add(norm_q, frame_sum_q) : frame_sum_q;
				n_has_norm = 1'b1;
				if (32'(fc_q) < MAX_FRAMES) n_fc = fc_q + FC_W'(1);
				n_open = 1'b0; n_full = 1'b0;
				n_vc = '0; n_ac = '0;
			end
			case (item.func)
				FUNC_FRAME: begin
					if (32'(n_fc) < MAX_FRAMES) begin
						n_open = 1'b1; n_full = 1'b0;
						n_frame_sum = sc;
						n_ac = '0; n_vc = '0;
						for (int j = 0; j < MAX_REFS; j++)
							if (j < 32'(nref) && 32'(lbl_q[j][0]) == 32'(n_fc))
								n_ref_sums[j] = sat32(52'(ref_sums_q[j]) + 52'(sc));
					end
				end
				FUNC_VALUE: begin
					if (open_q && !full_q) begin
						if (32'(vc_q) < MAX_VALUES) begin
							counted = 1'b1;
							if (vc_q == '0) begin
								n_best = item.score; n_best_idx = '0; n_arg_lse = sc;
							end else begin
								if (item.score > best_q) begin
									n_best = item.score; n_best_idx = vc_q[9:0];
								end
								n_arg_lse = log_add(arg_lse_q, sc);
							end
							if (arg_ok)
								for (int j = 0; j < MAX_REFS; j++)
									if (j < 32'(nref) && 32'(lbl_q[j][0]) == 32'(fc_q)
											&& lbl_q[j][arg_word] == vc_q[9:0])
										n_ref_sums[j] = sat32(52'(ref_sums_q[j]) + 52'(sc));
							n_vc = vc_q + VC_W'(1);
						end
						if (item.last_value) begin
							push0           = 1'b1;
							res0.kind       = KIND_ARG;
							res0.frame_num  = fc_q[8:0];
							res0.arg_pos    = ac_q;
							res0.best_index = n_best_idx;
							res0.last       = 1'b1;
							if (counted || vc_q != '0)
								n_frame_sum = sat32(52'(frame_sum_q) + 52'(n_arg_lse));
							n_vc = '0;
							if (ac_q == 3'd7) n_full = 1'b1;
							else n_ac = ac_q + 3'd1;
						end
					end
				end
				FUNC_END: begin
					n_seq  = SEQ_POS;
					n_pos  = ref_sums_q[0];
					n_ridx = NREF_W'(1);
				end
				default: ;
			endcase
		end else begin
			unique case (seq_q)
				SEQ_IDLE: ;
				SEQ_POS: begin
					if (ridx_q < nref) begin
						n_pos  = log_add(pos_q, ref_sums_q[ridx_q[REF_W-1:0]]);
						n_ridx = ridx_q + NREF_W'(1);
					end else begin
						n_seq = SEQ_MUL;
					end
				end
				SEQ_MUL: n_seq = SEQ_OUT;
				SEQ_OUT: begin
					if (stat.room1) begin
						push0       = 1'b1;
						res0.kind   = KIND_LOSS;
						res0.amount = sat32(loss);
						res0.last   = 1'b1;
						for (int j = 0; j < MAX_REFS; j++) n_ref_sums[j] = '0;
						n_fc = '0; n_ac = '0; n_vc = '0;
						n_best = '0; n_best_idx = '0;
						n_arg_lse = '0; n_frame_sum = '0; n_norm = '0; n_gt = '0;
						n_open = 1'b0; n_has_norm = 1'b0; n_full = 1'b0;
						n_seq = SEQ_IDLE;
					end
				end
				default: n_seq = SEQ_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take && item.func == FUNC_LABEL)
			lbl_q[item.label_slot[4:3]][item.label_slot[2:0]] <= item.label_value;
		if (seq_q == SEQ_MUL)
			prod_q <= $signed({1'b0, lambda_q}) * (33'(gt_q) - 33'(norm_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lambda_q <= 16'd4096;
			refs_q   <= 3'd1;
			for (int j = 0; j < MAX_REFS; j++) ref_sums_q[j] <= '0;
			fc_q <= '0; ac_q <= '0; vc_q <= '0;
			best_q <= '0; best_idx_q <= '0;
			arg_lse_q <= '0; frame_sum_q <= '0; norm_q <= '0; gt_q <= '0;
			open_q <= 1'b0; has_norm_q <= 1'b0; full_q <= 1'b0;
			seq_q <= SEQ_IDLE; ridx_q <= '0; pos_q <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_LAMBDA: lambda_q <= cfg_data;
					CFG_REFS:   refs_q   <= cfg_data[2:0];
					default: ;
				endcase
			end
			ref_sums_q <= n_ref_sums;
			fc_q <= n_fc; ac_q <= n_ac; vc_q <= n_vc;
			best_q <= n_best; best_idx_q <= n_best_idx;
			arg_lse_q <= n_arg_lse; frame_sum_q <= n_frame_sum;
			norm_q <= n_norm; gt_q <= n_gt;
			open_q <= n_open; has_norm_q <= n_has_norm; full_q <= n_full;
			seq_q <= n_seq; ridx_q <= n_ridx; pos_q <= n_pos;
		end
	end

endmodule

>>> rtl/frame_crf_marginal_loss_unit.sv
// Top level of the frame CRF marginal loss unit: input register, example core
// and result queue. Depends on fcml_pkg, fcml_core and fcml_out_fifo.

// Label words, frame starts and value scores are taken one per cycle while
// the input does not stall: each word is registered in the input register,
// then folded into the running argmax, log-sum-exps and reference sums by the
// core, with results queued in a four-word output queue. An end-of-example
// word holds the input while the core runs its loss sequence (one log-add per
// reference after the first, a step to leave that loop, then the lambda
// multiply and the final sum), and longer while the queue is full. Input
// stalls while the queue has fewer than two free slots.
module frame_crf_marginal_loss_unit import fcml_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [4:0]  label_slot,
	input  logic [9:0]  label_value,
	input  logic signed [23:0] score,
	input  logic        last_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [8:0]  frame_num,
	output logic [2:0]  arg_pos,
	output logic [9:0]  best_index,
	output logic signed [31:0] amount,
	output logic        last,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	item_t      item_s1;
	logic       v_s1;
	logic       take;
	fifo_stat_t stat;
	logic       push0, push1;
	res_t       res0, res1, head;

	assign in_stall  = v_s1 && !take;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1.func        <= func;
			item_s1.label_slot  <= label_slot;
			item_s1.label_value <= label_value;
			item_s1.score       <= score;
			item_s1.last_value  <= last_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (!in_stall) v_s1 <= in_valid;
	end

	fcml_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (v_s1),
		.item       (item_s1),
		.take       (take),
		.stat       (stat),
		.push0      (push0),
		.res0       (res0),
		.push1      (push1),
		.res1       (res1),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	fcml_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push0     (push0),
		.res0      (res0),
		.push1     (push1),
		.res1      (res1),
		.stat      (stat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_res   (head)
	);

	assign kind       = head.kind;
	assign frame_num  = head.frame_num;
	assign arg_pos    = head.arg_pos;
	assign best_index = head.best_index;
	assign amount     = head.amount;
	assign last       = head.last;

endmodule

>>> rtl/fcml_checker.sv
// Port-level checks for the frame CRF marginal loss unit, bound to the top
// level. Depends on fcml_pkg.
module fcml_checker import fcml_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  kind,
	input logic [8:0]  frame_num,
	input logic [2:0]  arg_pos,
	input logic [9:0]  best_index,
	input logic [31:0] amount,
	input logic        last
);

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(amount) && $stable(kind))
		else $error("stalled result changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> kind <= KIND_LOSS)
		else $error("undefined result kind");

	// An argmax word carries no amount and always closes its input's results.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ARG |-> amount == '0 && last)
		else $error("argmax word malformed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_LOSS |-> frame_num == '0 && arg_pos == '0
			&& best_index == '0 && last)
		else $error("loss word malformed");

endmodule

bind frame_crf_marginal_loss_unit fcml_checker u_fcml_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.kind       (kind),
	.frame_num  (frame_num),
	.arg_pos    (arg_pos),
	.best_index (best_index),
	.amount     (amount),
	.last       (last)
);

>>> dv/tb_frame_crf_marginal_loss_unit.sv
// Testbench for the frame CRF marginal loss unit: directed and random examples,
// checked against a built-in predictor of argmax, marginals and loss.
// Depends on fcml_pkg and the frame_crf_marginal_loss_unit RTL.
module tb_frame_crf_marginal_loss_unit;
	import fcml_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] func = FUNC_LABEL;
	logic [4:0] label_slot = '0;
	logic [9:0] label_value = '0;
	logic signed [23:0] score = '0;
	logic last_value = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic [8:0] frame_num;
	logic [2:0] arg_pos;
	logic [9:0] best_index;
	logic signed [31:0] amount;
	logic last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = CFG_LAMBDA;
	logic [15:0] cfg_data = '0;

	frame_crf_marginal_loss_unit DUT (.*);

	always #4 clk = ~clk;

	// Predictor state.
	logic [15:0] lam_w;
	logic [2:0] nref_cfg;
	logic [9:0] labels [32];
	logic [31:0] label_set;
	longint ref_acc [4];
	int unsigned frames, args, nvals;
	longint best_sc, arg_sum, frame_acc, norm_acc, gt_acc;
	int unsigned best_at;
	bit frame_open, norm_set, args_full;

	res_t expected_q[$];
	int errors = 0;
	int max_gap = 18;
	bit hold_out = 1'b0;

	const longint la_tab [37] = '{2839, 2359, 1942, 1585, 1283, 1032, 825, 656, 520,
		410, 323, 254, 199, 156, 122, 95, 74, 58, 45, 35, 28, 21, 17, 13, 10, 8,
		6, 5, 4, 3, 2, 2, 1, 1, 1, 1, 1};

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint lse2(longint a, longint b);
		longint hi, lo, d;
		hi = (a > b) ? a : b;
		lo = (a > b) ? b : a;
		d = (hi - lo) >>> 10;
		return clip32(hi + ((d < 37) ? la_tab[d] : 0));
	endfunction

	function automatic longint div4096_round(longint x);
		longint y;
		y = x + 2048;
		if (y >= 0) return y >>> 12;
		return -(((-y) + 4095) >>> 12);
	endfunction

	function automatic res_t mk(logic [1:0] k, int unsigned fr, int unsigned p,
			int unsigned bi, longint amt, bit lst);
		res_t r;
		r.kind = k;
		r.frame_num = fr[8:0];
		r.arg_pos = p[2:0];
		r.best_index = bi[9:0];
		r.amount = amt[31:0];
		r.last = lst;
		return r;
	endfunction

	task automatic add_expected(res_t r);
		expected_q.insert(expected_q.size(), r);
	endtask

	function automatic int unsigned active_refs();
		if (nref_cfg == 0) return 1;
		if (nref_cfg > MAX_REFS) return MAX_REFS;
		return nref_cfg;
	endfunction

	task automatic clear_example();
		for (int j = 0; j < 4; j++) ref_acc[j] = 0;
		frames = 0; args = 0; nvals = 0; best_sc = 0; best_at = 0;
		arg_sum = 0; frame_acc = 0; norm_acc = 0; gt_acc = 0;
		frame_open = 0; norm_set = 0; args_full = 0;
	endtask

	task automatic close_frame(bit lst);
		if (frames == labels[0]) gt_acc = frame_acc;
		norm_acc = norm_set ? lse2(norm_acc, frame_acc) : frame_acc;
		norm_set = 1;
		add_expected(mk(KIND_MARG, frames, 0, 0, frame_acc, lst));
		if (frames < MAX_FRAMES) frames++;
		frame_open = 0; args_full = 0; nvals = 0; args = 0;
	endtask

	task automatic predict_word(item_t it);
		longint sc, pos, loss;
		int unsigned nr;
		sc = it.score;
		nr = active_refs();
		case (it.func)
			FUNC_LABEL: begin
				labels[it.label_slot] = it.label_value;
				label_set[it.label_slot] = 1'b1;
			end
			FUNC_FRAME: begin
				if (frame_open) close_frame(1);
				if (frames < MAX_FRAMES) begin
					frame_open = 1; args_full = 0; frame_acc = sc; args = 0; nvals = 0;
					for (int j = 0; j < nr; j++)
						if (labels[j*LABEL_WIDTH] == frames) ref_acc[j] = clip32(ref_acc[j] + sc);
				end
			end
			FUNC_VALUE: begin
				if (frame_open && !args_full) begin
					if (nvals < MAX_VALUES) begin
						if (nvals == 0) begin
							best_sc = sc; best_at = 0; arg_sum = sc;
						end else begin
							if (sc > best_sc) begin
								best_sc = sc; best_at = nvals;
							end
							arg_sum = lse2(arg_sum, sc);
						end
						if (args + 1 < LABEL_WIDTH)
							for (int j = 0; j < nr; j++)
								if (labels[j*LABEL_WIDTH] == frames &&
										labels[j*LABEL_WIDTH + 1 + args] == nvals)
									ref_acc[j] = clip32(ref_acc[j] + sc);
						nvals++;
					end
					if (it.last_value) begin
						add_expected(mk(KIND_ARG, frames, args, best_at, 0, 1));
						if (nvals > 0) frame_acc = clip32(frame_acc + arg_sum);
						nvals = 0;
						if (args >= 7) args_full = 1;
						else args++;
					end
				end
			end
			default: begin
				if (frame_open) close_frame(0);
				pos = ref_acc[0];
				for (int j = 1; j < nr; j++) pos = lse2(pos, ref_acc[j]);
				loss = pos - norm_acc + div4096_round(longint'(lam_w) * (gt_acc - norm_acc));
				add_expected(mk(KIND_LOSS, 0, 0, 0, clip32(loss), 1));
				clear_example();
			end
		endcase
	endtask

	// Sends one word after a random gap; the prediction is made on acceptance.
	// The word stays offered after its acceptance edge until the next falling
	// edge, where the next word or drain() takes the input over.
	task automatic send_word(logic [1:0] f, logic [4:0] sl, logic [9:0] lv,
			logic signed [23:0] sc, logic lvb);
		item_t it;
		int gap;
		gap = $urandom_range(max_gap, 0);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		it.func = f; it.label_slot = sl; it.label_value = lv; it.score = sc;
		it.last_value = lvb;
		func <= f; label_slot <= sl; label_value <= lv; score <= sc;
		last_value <= lvb; in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_word(it);
	endtask

	// Result checker and receiver stall.
	always @(posedge clk) begin
		res_t e;
		if (out_valid && !out_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result kind=%0d amount=%0d", $time, kind, amount);
				errors++;
			end else begin
				e = expected_q.pop_front();
				if (kind !== e.kind || frame_num !== e.frame_num || arg_pos !== e.arg_pos ||
						best_index !== e.best_index || amount !== e.amount || last !== e.last) begin
					$display("%0t: mismatch expected k=%0d f=%0d p=%0d b=%0d a=%0d l=%0d",
						$time, e.kind, e.frame_num, e.arg_pos, e.best_index, e.amount, e.last);
					$display("%0t:          actual   k=%0d f=%0d p=%0d b=%0d a=%0d l=%0d",
						$time, kind, frame_num, arg_pos, best_index, amount, last);
					errors++;
				end
			end
		end
	end

	int stall_left = 0;
	always @(negedge clk) begin
		if (hold_out) out_stall <= 1'b1;
		else if (max_gap == 0) out_stall <= 1'b0;
		else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			stall_left <= $urandom_range(max_gap, 0);
			out_stall <= 1'b0;
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		@(negedge clk);
		cfg_index <= idx; cfg_data <= val; cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_LAMBDA) lam_w = val;
		else nref_cfg = val[2:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (MAX_REFS + 12) @(posedge clk);
	endtask

	function automatic logic signed [23:0] rnd_score();
		case ($urandom_range(5, 0))
			0: return 24'sh7FFFFF;
			1: return 24'sh800000;
			2: return 24'($urandom_range(32768, 0) - 16384);
			default: return 24'($urandom);
		endcase
	endfunction

	// One well-formed example; references mostly point at streamed frames.
	task automatic random_example(int nframes);
		int nr, na, nv;
		nr = active_refs();
		for (int r = 0; r < nr; r++)
			for (int w = 0; w < LABEL_WIDTH; w++)
				send_word(FUNC_LABEL, 5'(r*LABEL_WIDTH + w),
					(w == 0) ? 10'($urandom_range(nframes, 0)) : 10'($urandom_range(4, 0)),
					24'sd0, 1'b0);
		for (int f = 0; f < nframes; f++) begin
			send_word(FUNC_FRAME, 5'($urandom), 10'($urandom), rnd_score(), 1'($urandom));
			na = $urandom_range(3, 0);
			if ($urandom_range(9, 0) == 0) na = 10;
			for (int a = 0; a < na; a++) begin
				nv = $urandom_range(5, 1);
				for (int v = 0; v < nv; v++)
					send_word(FUNC_VALUE, 5'($urandom), 10'($urandom), rnd_score(), v == nv - 1);
			end
			if ($urandom_range(7, 0) == 0) send_word(FUNC_VALUE, 5'd0, 10'd0, rnd_score(), 1'b0);
		end
		send_word(FUNC_END, 5'($urandom), 10'($urandom), 24'($urandom), 1'($urandom));
	endtask

	task automatic test_directed();
		for (int s = 0; s < 32; s++)
			send_word(FUNC_LABEL, 5'(s), (s % 8 == 0) ? 10'd0 : 10'h3FF, 24'sd0, 1'b0);
		send_word(FUNC_LABEL, 5'd1, 10'd0, 24'sd0, 1'b0);
		send_word(FUNC_VALUE, 5'd0, 10'd0, 24'sh123, 1'b1);
		send_word(FUNC_FRAME, 5'd0, 10'd0, 24'sh7FFFFF, 1'b0);
		send_word(FUNC_VALUE, 5'd0, 10'd0, 24'sh7FFFFF, 1'b0);
		send_word(FUNC_VALUE, 5'd0, 10'd0, 24'sh7FFFFF, 1'b1);
		send_word(FUNC_VALUE, 5'd0, 10'd0, 24'sh800000, 1'b0);
		send_word(FUNC_FRAME, 5'd0, 10'd0, 24'sh800000, 1'b0);
		send_word(FUNC_VALUE, 5'd0, 10'd0, 24'sh800000, 1'b0);
		send_word(FUNC_VALUE, 5'd0, 10'd0, 24'sh000100, 1'b1);
		send_word(FUNC_END, 5'd0, 10'd0, 24'sd0, 1'b0);
		send_word(FUNC_END, 5'h1F, 10'h3FF, 24'shFFFFFF, 1'b1);
		drain();
	endtask

	task automatic test_config_sweep();
		logic [15:0] lam [4] = '{16'd0, 16'hFFFF, 16'd4096, 16'd123};
		logic [2:0] nr [4] = '{3'd1, 3'd4, 3'd0, 3'd7};
		for (int p = 0; p < 4; p++) begin
			write_reg(CFG_LAMBDA, lam[p]);
			write_reg(CFG_REFS, {13'd0, nr[p]});
			max_gap = (p == 2) ? 0 : 18;
			random_example($urandom_range(3, 1));
			drain();
		end
		max_gap = 18;
	endtask

	// The receiver holds off while words arrive back to back, so the queue
	// fills and the input stalls.
	task automatic test_backpressure();
		max_gap = 0;
		hold_out = 1'b1;
		fork
			random_example(3);
			begin
				repeat (300) @(posedge clk);
				hold_out = 1'b0;
			end
		join
		max_gap = 18;
		drain();
	endtask

	task automatic test_many_frames();
		write_reg(CFG_REFS, 16'd2);
		max_gap = 1;
		for (int r = 0; r < MAX_REFS; r++)
			send_word(FUNC_LABEL, 5'(r*LABEL_WIDTH), 10'd520, 24'sd0, 1'b0);
		for (int f = 0; f < 514; f++) begin
			send_word(FUNC_FRAME, 5'd0, 10'd0, 24'($urandom_range(2000, 0)), 1'b0);
			if (f >= 510) send_word(FUNC_VALUE, 5'd0, 10'd0, 24'sh1000, 1'b1);
		end
		send_word(FUNC_END, 5'd0, 10'd0, 24'sd0, 1'b0);
		max_gap = 18;
		drain();
	endtask

	initial begin
		lam_w = 16'd4096;
		nref_cfg = 3'd1;
		label_set = '0;
		for (int s = 0; s < 32; s++) labels[s] = '0;
		clear_example();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_config_sweep();
		test_backpressure();
		test_many_frames();
		drain();
		if (errors == 0) $display("frame_crf_marginal_loss_unit verification clean");
		else $display("frame_crf_marginal_loss_unit verification failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("frame_crf_marginal_loss_unit verification failed");
		$finish;
	end
endmodule
